/* src/lbr_pkg.sv */
// ----------------------------------------------------------------------------
// lbr_pkg
// shared codes, types and helpers for the link bring-up retry controller
// ----------------------------------------------------------------------------
package lbr_pkg;

    // node states
    localparam logic [2:0] ST_UNCONF = 3'd0;
    localparam logic [2:0] ST_PAIR   = 3'd1;
    localparam logic [2:0] ST_CONF   = 3'd2;
    localparam logic [2:0] ST_OPER   = 3'd3;
    localparam logic [2:0] ST_ERR    = 3'd4;
    localparam logic [2:0] ST_REPAIR = 3'd5;

    // event codes
    localparam logic [3:0] EV_BOOT          = 4'd0;
    localparam logic [3:0] EV_CONFIG_FOUND  = 4'd1;
    localparam logic [3:0] EV_NO_CONFIG     = 4'd2;
    localparam logic [3:0] EV_PAIR_START    = 4'd3;
    localparam logic [3:0] EV_PAIR_CONFIG   = 4'd4;
    localparam logic [3:0] EV_LINK_UP       = 4'd5;
    localparam logic [3:0] EV_LINK_FAIL     = 4'd6;
    localparam logic [3:0] EV_API_OK        = 4'd7;
    localparam logic [3:0] EV_API_FAIL      = 4'd8;
    localparam logic [3:0] EV_RESET         = 4'd9;
    localparam logic [3:0] EV_ERROR         = 4'd10;
    localparam logic [3:0] EV_RETRY_TIMEOUT = 4'd11;
    localparam logic [3:0] EV_RETRIES_OUT   = 4'd12;
    localparam logic [3:0] EV_NEW_CREDS     = 4'd13;
    localparam logic [3:0] EV_OLD_LINK      = 4'd14;
    localparam logic [3:0] EV_RETRY_TICK    = 4'd15;

    localparam int          STATE_W       = 3;
    localparam int          COUNT_W       = 5;
    localparam int          DELAY_W       = 26;
    localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;
    localparam logic [4:0]  COUNT_CEILING = 5'd16;
    localparam logic [25:0] DELAY_BASE_MS = 26'd1000;

    typedef logic [STATE_W-1:0] state_t;
    typedef logic [COUNT_W-1:0] count_t;

    // outcome of one event
    typedef struct packed {
        state_t state;
        count_t count;
        logic   changed;
    } step_t;

    // saturating retry increment
    function automatic count_t bump(input count_t c);
        return (c >= COUNT_CEILING) ? COUNT_CEILING : count_t'(c + 5'd1);
    endfunction

    // backoff, 1000 ms shifted left by the count
    function automatic logic [DELAY_W-1:0] backoff_ms(input count_t c);
        return DELAY_BASE_MS << c;
    endfunction

endpackage

/* src/lbr_next.sv */
// ----------------------------------------------------------------------------
// lbr_next
// transition table and retry counter update for one event
// ----------------------------------------------------------------------------
module lbr_next
    import lbr_pkg::*;
(
    input  state_t     state,
    input  count_t     count,
    input  logic [3:0] retry_limit,
    input  logic [3:0] event_code,
    output step_t      step
);

    state_t nxt;
    count_t cnt;
    count_t bumped;
    count_t max_ext;

    assign bumped  = bump(count);
    assign max_ext = {1'b0, retry_limit};

    always_comb
    begin
        nxt = state;
        cnt = count;
        unique case (state)
            ST_UNCONF:
            begin
                if (event_code == EV_CONFIG_FOUND)    nxt = ST_CONF;
                else if (event_code == EV_PAIR_START) nxt = ST_PAIR;
                else if (event_code == EV_ERROR)      nxt = ST_ERR;
            end
            ST_PAIR:
            begin
                if (event_code == EV_PAIR_CONFIG || event_code == EV_LINK_UP)
                    nxt = ST_CONF;
                else if (event_code == EV_LINK_FAIL || event_code == EV_ERROR)
                    nxt = ST_ERR;
                else if (event_code == EV_RESET)
                    nxt = ST_UNCONF;
            end
            ST_CONF:
            begin
                if (event_code == EV_LINK_UP)
                begin
                    cnt = '0;
                end
                else if (event_code == EV_API_OK)
                begin
                    cnt = '0;
                    nxt = ST_OPER;
                end
                else if (event_code == EV_LINK_FAIL)
                begin
                    cnt = bumped;
                    if (bumped >= max_ext)
                        nxt = ST_REPAIR;
                end
                else if (event_code == EV_API_FAIL || event_code == EV_ERROR)
                begin
                    nxt = ST_ERR;
                end
                else if (event_code == EV_RESET)
                begin
                    nxt = ST_UNCONF;
                end
            end
            ST_OPER:
            begin
                if (event_code == EV_LINK_FAIL)
                    nxt = ST_CONF;
                else if (event_code == EV_API_FAIL || event_code == EV_ERROR)
                    nxt = ST_ERR;
                else if (event_code == EV_RESET)
                    nxt = ST_UNCONF;
            end
            ST_ERR:
            begin
                if (event_code == EV_RETRY_TIMEOUT)
                begin
                    if (count < max_ext)
                    begin
                        cnt = bumped;
                        nxt = ST_CONF;
                    end
                    else
                    begin
                        nxt = ST_REPAIR;
                    end
                end
                else if (event_code == EV_RETRIES_OUT)
                begin
                    nxt = ST_REPAIR;
                end
                else if (event_code == EV_RESET)
                begin
                    cnt = '0;
                    nxt = ST_UNCONF;
                end
                else if (event_code == EV_LINK_UP)
                begin
                    cnt = '0;
                    nxt = ST_CONF;
                end
                else if (event_code == EV_PAIR_START)
                begin
                    nxt = ST_PAIR;
                end
            end
            ST_REPAIR:
            begin
                if (event_code == EV_NEW_CREDS || event_code == EV_OLD_LINK ||
                    event_code == EV_PAIR_CONFIG || event_code == EV_LINK_UP)
                begin
                    cnt = '0;
                    nxt = ST_CONF;
                end
                else if (event_code == EV_RESET)
                begin
                    cnt = '0;
                    nxt = ST_UNCONF;
                end
            end
            default:
            begin
                nxt = state;
                cnt = count;
            end
        endcase
    end

    assign step.state   = nxt;
    assign step.count   = cnt;
    assign step.changed = (nxt != state);

endmodule

/* src/link_bringup_retry_fsm_core.sv */
// ----------------------------------------------------------------------------
// link_bringup_retry_fsm_core
// network node bring-up controller with retry counter and backoff delay
// ----------------------------------------------------------------------------
// Each event word yields exactly one result word: the new node state, the
// retry count, the backoff delay (1000 ms shifted left by the count), a flag
// for a real state change and the state before the event. An event is taken
// into an input register, runs through the transition table and counter
// update and lands in the result register, so one event is accepted per
// clock as long as results are taken; out_valid rises when the event enters
// the result register. The retry limit is written through the cfg port,
// which is always ready, and resets to 5; write it only while idle.
// ----------------------------------------------------------------------------
module link_bringup_retry_fsm_core
    import lbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // retry limit register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          retry_limit,

    // event channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          event_code,

    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATE_W-1:0]  node_state,
    output logic [COUNT_W-1:0]  retry_count,
    output logic [DELAY_W-1:0]  retry_delay_ms,
    output logic                state_changed,
    output logic [STATE_W-1:0]  previous_state
);

    // config register
    logic [3:0] retry_limit_reg;

    // input stage
    logic       ev_valid_reg;
    logic [3:0] ev_reg;

    // controller state
    state_t     state_reg;
    count_t     count_reg;

    // result stage
    logic                out_valid_reg;
    state_t              node_state_reg;
    count_t              retry_count_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic                changed_reg;
    state_t              prev_state_reg;

    step_t      step;
    logic       res_free;
    logic       ev_advance;
    logic       in_take;

    assign cfg_ready = 1'b1;

    // result slot opens when empty or being drained this cycle
    assign res_free   = !out_valid_reg || !out_stall;
    assign ev_advance = ev_valid_reg && res_free;
    assign in_stall   = ev_valid_reg && !res_free;
    assign in_take    = in_valid && !in_stall;

    lbr_next u_next (
        .state       (state_reg),
        .count       (count_reg),
        .retry_limit (retry_limit_reg),
        .event_code  (ev_reg),
        .step        (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            retry_limit_reg <= retry_limit;
        end
    end

    // input register, refilled as the held word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            ev_valid_reg <= 1'b1;
        end
        else if (ev_advance)
        begin
            ev_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg <= event_code;
        end
    end

    // state and counter commit when the event enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_UNCONF;
            count_reg <= '0;
        end
        else if (ev_advance)
        begin
            state_reg <= step.state;
            count_reg <= step.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= ev_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_advance)
        begin
            node_state_reg  <= step.state;
            retry_count_reg <= step.count;
            delay_reg       <= backoff_ms(step.count);
            changed_reg     <= step.changed;
            prev_state_reg  <= state_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign node_state     = node_state_reg;
    assign retry_count    = retry_count_reg;
    assign retry_delay_ms = delay_reg;
    assign state_changed  = changed_reg;
    assign previous_state = prev_state_reg;

endmodule

/* tb/link_bringup_retry_fsm_core_test.sv */
// ----------------------------------------------------------------------------
// link_bringup_retry_fsm_core_test
// self-checking bench for the node bring-up controller with retry counter
// ----------------------------------------------------------------------------
// Event words come from a queue through a clocked driver. A shadow of the
// state machine works out each result word when its event is taken. A clocked
// monitor checks every result word against the oldest shadow result. Both
// sides idle in random bursts, and the receiver once stalls for a long
// stretch so the block backs up. The sender also pauses once until the block
// has drained. The retry limit gets several values, including 0, 1 and 15,
// and each value is written only while the block is idle.
// ----------------------------------------------------------------------------
module link_bringup_retry_fsm_core_test;
    import lbr_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 80;
    localparam int LATENCY_SLACK = 4;

    // one result word as the shadow sees it
    typedef struct packed {
        state_t               node_state;
        count_t               count;
        logic [DELAY_W-1:0]   delay;
        logic                 changed;
        state_t               prior;
    } node_report_t;

    logic               clk;
    logic               rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_limit = 4'd0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [3:0]         event_code = EV_BOOT;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STATE_W-1:0] node_state;
    logic [COUNT_W-1:0] retry_count;
    logic [DELAY_W-1:0] retry_delay_ms;
    logic               state_changed;
    logic [STATE_W-1:0] previous_state;

    // event words not yet offered, and result words not yet seen
    logic [3:0]         pending_events[$];
    node_report_t       awaited_reports[$];

    // shadow of the controller
    state_t             shadow_state = ST_UNCONF;
    count_t             shadow_count = '0;
    logic [3:0]         retry_limit  = RETRY_LIMIT_RESET;

    int                 mismatch_count  = 0;
    int                 cycle_count     = 0;
    int                 send_gap        = 0;
    int                 stall_left      = 0;
    int                 hold_left       = 0;
    int                 long_holds_asked = 0;
    int                 long_holds_done  = 0;
    logic               quiet = 1'b0;

    link_bringup_retry_fsm_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .retry_limit    (cfg_limit),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .event_code     (event_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node_state     (node_state),
        .retry_count    (retry_count),
        .retry_delay_ms (retry_delay_ms),
        .state_changed  (state_changed),
        .previous_state (previous_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // retry counter stops at the ceiling
    function automatic count_t saturating_inc(input count_t c);
        return (c >= COUNT_CEILING) ? COUNT_CEILING : count_t'(c + 5'd1);
    endfunction

    // run one event through the shadow and queue the result word it implies
    task automatic advance_node(input logic [3:0] ev);
        state_t       prior;
        state_t       nxt;
        count_t       cnt;
        node_report_t rep;
        prior = shadow_state;
        nxt   = prior;
        cnt   = shadow_count;
        case (prior)
            ST_UNCONF:
            begin
                if (ev == EV_CONFIG_FOUND)
                    nxt = ST_CONF;
                else if (ev == EV_PAIR_START)
                    nxt = ST_PAIR;
                else if (ev == EV_ERROR)
                    nxt = ST_ERR;
            end
            ST_PAIR:
            begin
                if (ev == EV_PAIR_CONFIG || ev == EV_LINK_UP)
                    nxt = ST_CONF;
                else if (ev == EV_LINK_FAIL || ev == EV_ERROR)
                    nxt = ST_ERR;
                else if (ev == EV_RESET)
                    nxt = ST_UNCONF;
            end
            ST_CONF:
            begin
                if (ev == EV_LINK_UP)
                    cnt = '0;
                else if (ev == EV_API_OK)
                begin
                    cnt = '0;
                    nxt = ST_OPER;
                end
                else if (ev == EV_LINK_FAIL)
                begin
                    // count first, then give up once the limit is reached
                    cnt = saturating_inc(cnt);
                    if (cnt >= {1'b0, retry_limit})
                        nxt = ST_REPAIR;
                end
                else if (ev == EV_API_FAIL || ev == EV_ERROR)
                    nxt = ST_ERR;
                else if (ev == EV_RESET)
                    nxt = ST_UNCONF;
            end
            ST_OPER:
            begin
                if (ev == EV_LINK_FAIL)
                    nxt = ST_CONF;
                else if (ev == EV_API_FAIL || ev == EV_ERROR)
                    nxt = ST_ERR;
                else if (ev == EV_RESET)
                    nxt = ST_UNCONF;
            end
            ST_ERR:
            begin
                if (ev == EV_RETRY_TIMEOUT)
                begin
                    // retry only while below the limit, count left alone otherwise
                    if (cnt < {1'b0, retry_limit})
                    begin
                        cnt = saturating_inc(cnt);
                        nxt = ST_CONF;
                    end
                    else
                        nxt = ST_REPAIR;
                end
                else if (ev == EV_RETRIES_OUT)
                    nxt = ST_REPAIR;
                else if (ev == EV_RESET)
                begin
                    cnt = '0;
                    nxt = ST_UNCONF;
                end
                else if (ev == EV_LINK_UP)
                begin
                    cnt = '0;
                    nxt = ST_CONF;
                end
                else if (ev == EV_PAIR_START)
                    nxt = ST_PAIR;
            end
            ST_REPAIR:
            begin
                if (ev == EV_NEW_CREDS || ev == EV_OLD_LINK ||
                    ev == EV_PAIR_CONFIG || ev == EV_LINK_UP)
                begin
                    cnt = '0;
                    nxt = ST_CONF;
                end
                else if (ev == EV_RESET)
                begin
                    cnt = '0;
                    nxt = ST_UNCONF;
                end
            end
            default:
            begin
            end
        endcase
        shadow_state   = nxt;
        shadow_count   = cnt;
        rep.node_state = nxt;
        rep.count      = cnt;
        rep.delay      = DELAY_BASE_MS << cnt;
        rep.changed    = (nxt != prior);
        rep.prior      = prior;
        awaited_reports.push_back(rep);
    endtask

    // event driver: holds a stalled word, otherwise idles in bursts or
    // offers the next queued word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            event_code <= EV_BOOT;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_node(event_code);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() == 0)
                    in_valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    // start an idle burst of random length
                    send_gap = $urandom_range(1, 13) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid   <= 1'b1;
                    event_code <= pending_events.pop_front();
                end
            end
        end
    end

    // receiver stall: one long hold on request, else random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (long_holds_done != long_holds_asked)
            begin
                hold_left = LONG_HOLD;
                long_holds_done = long_holds_done + 1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endfunction

    // result monitor: every taken result word against the oldest shadow result
    always @(posedge clk)
    begin : watch_results
        node_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("result word with nothing awaited: node_state %0d", node_state);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("node_state", want.node_state, node_state);
                compare_field("retry_count", want.count, retry_count);
                compare_field("retry_delay_ms", want.delay, retry_delay_ms);
                compare_field("state_changed", want.changed, state_changed);
                compare_field("previous_state", want.prior, previous_state);
            end
        end
    end

    // wait until every queued word went in and every result came out
    task automatic settle();
        @(negedge clk);
        while (pending_events.size() != 0 || in_valid || awaited_reports.size() != 0)
            @(negedge clk);
        repeat (LATENCY_SLACK) @(negedge clk);
    endtask

    // retry limit write, only ever called while the block is idle
    task automatic write_retry_limit(input logic [3:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        retry_limit = value;
        @(negedge clk);
    endtask

    // random traffic: mostly well-formed bring-up and recovery sequences with
    // random lengths, plus some raw noise
    task automatic queue_events(input int n);
        int target;
        int reps;
        int i;
        target = pending_events.size() + n;
        while (pending_events.size() < target)
        begin
            case ($urandom_range(0, 15))
                0, 1:
                begin
                    // bring-up through pairing
                    pending_events.push_back(EV_PAIR_START);
                    pending_events.push_back($urandom_range(0, 1) ? EV_PAIR_CONFIG
                                                                  : EV_LINK_UP);
                    pending_events.push_back(EV_API_OK);
                end
                2:
                begin
                    pending_events.push_back(EV_CONFIG_FOUND);
                    pending_events.push_back(EV_API_OK);
                end
                3, 4, 5:
                begin
                    // wifi failure run, now and then a link up
                    reps = $urandom_range(1, 17);
                    for (i = 0; i < reps; i++)
                        pending_events.push_back(($urandom_range(0, 9) == 0) ? EV_LINK_UP
                                                                             : EV_LINK_FAIL);
                end
                6, 7, 8:
                begin
                    // error and retry timeout loop, climbs the counter
                    pending_events.push_back($urandom_range(0, 1) ? EV_ERROR : EV_API_FAIL);
                    reps = $urandom_range(1, 17);
                    for (i = 0; i < reps; i++)
                    begin
                        pending_events.push_back(EV_RETRY_TIMEOUT);
                        pending_events.push_back(EV_ERROR);
                    end
                end
                9, 10:
                begin
                    // give up and come back from re-pairing
                    pending_events.push_back(EV_RETRIES_OUT);
                    case ($urandom_range(0, 4))
                        0: pending_events.push_back(EV_NEW_CREDS);
                        1: pending_events.push_back(EV_OLD_LINK);
                        2: pending_events.push_back(EV_PAIR_CONFIG);
                        3: pending_events.push_back(EV_LINK_UP);
                        default: pending_events.push_back(EV_RESET);
                    endcase
                end
                11:
                    pending_events.push_back(EV_RESET);
                12, 13:
                begin
                    reps = $urandom_range(1, 4);
                    for (i = 0; i < reps; i++)
                        pending_events.push_back(4'($urandom_range(0, 15)));
                end
                default:
                begin
                    // operational drop and return
                    pending_events.push_back(EV_LINK_FAIL);
                    pending_events.push_back(EV_API_OK);
                    pending_events.push_back(EV_API_FAIL);
                    pending_events.push_back(EV_LINK_UP);
                end
            endcase
        end
    endtask

    // runaway guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk at the reset limit: every event, every state, events
        // with no transition, and transitions back to the same state
        pending_events = '{EV_BOOT, EV_NO_CONFIG, EV_PAIR_START, EV_PAIR_CONFIG,
                           EV_LINK_FAIL, EV_LINK_UP, EV_API_OK, EV_RETRY_TICK,
                           EV_LINK_FAIL, EV_API_FAIL, EV_RETRY_TIMEOUT, EV_ERROR,
                           EV_RETRIES_OUT, EV_OLD_LINK, EV_ERROR, EV_RESET,
                           EV_CONFIG_FOUND, EV_RESET, EV_ERROR, EV_PAIR_START,
                           EV_LINK_FAIL, EV_LINK_UP, EV_RETRIES_OUT, EV_NEW_CREDS};
        settle();

        // highest limit, long retry climbs up to the counter ceiling
        write_retry_limit(4'd15);
        queue_events(300);
        settle();

        // zero limit, every link failure while configuring and every retry timeout goes straight to re-pairing
        write_retry_limit(4'd0);
        queue_events(150);
        settle();

        // lowest nonzero limit, sender pauses halfway until the block drains
        write_retry_limit(4'd1);
        queue_events(150);
        settle();
        queue_events(150);
        settle();

        // mid-range limit, receiver holds off long enough to back up the input
        write_retry_limit(4'($urandom_range(2, 14)));
        queue_events(300);
        while (pending_events.size() > 150)
            @(negedge clk);
        long_holds_asked = long_holds_asked + 1;
        settle();

        // last part at full rate with no idling on either side
        write_retry_limit(4'($urandom_range(0, 15)));
        quiet = 1'b1;
        queue_events(350);
        settle();

        if (mismatch_count == 0 && awaited_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
